@@ hdl/ogom_pkg.sv @@
`timescale 1ns / 1ps

package ogom_pkg;

  localparam int POS_W  = 16;
  localparam int CELL_W = 17;
  localparam int DIST_W = 18;
  localparam int CFG_W  = 18;
  localparam int IDX_W  = 2;

  localparam logic [2:0] FN_CHECK   = 3'd0;
  localparam logic [2:0] FN_QUERY   = 3'd1;
  localparam logic [2:0] FN_CLAIM   = 3'd2;
  localparam logic [2:0] FN_RELEASE = 3'd3;
  localparam logic [2:0] FN_MOVE    = 3'd4;

  localparam logic [IDX_W-1:0] REG_GRID_COLS      = 2'd0;
  localparam logic [IDX_W-1:0] REG_GRID_ROWS      = 2'd1;
  localparam logic [IDX_W-1:0] REG_CELL_SHIFT     = 2'd2;
  localparam logic [IDX_W-1:0] REG_MOVE_THRESHOLD = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_LOOK,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic [2:0]               func;
    logic [7:0]               owner_id;
    logic signed [CELL_W-1:0] new_c;
    logic signed [CELL_W-1:0] new_r;
    logic signed [CELL_W-1:0] old_c;
    logic signed [CELL_W-1:0] old_r;
    logic [POS_W-1:0]         dx;
    logic [POS_W-1:0]         dy;
    logic [POS_W-1:0]         dz;
  } item_t;

  // truncate toward zero after dividing by 2**sh
  function automatic logic signed [CELL_W-1:0] to_cell(input logic signed [POS_W-1:0] v,
                                                       input logic [3:0] sh);
    logic signed [CELL_W-1:0] ext;
    logic [CELL_W-1:0]        mag;
    logic [CELL_W-1:0]        q;
    ext = $signed({v[POS_W-1], v});
    mag = v[POS_W-1] ? CELL_W'(-ext) : CELL_W'(ext);
    q   = mag >> sh;
    return v[POS_W-1] ? $signed(CELL_W'(0) - q) : $signed(q);
  endfunction

  function automatic logic [POS_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
    return d[POS_W] ? POS_W'(-d) : POS_W'(d);
  endfunction

endpackage

@@ hdl/ogom_ram.sv @@
`timescale 1ns / 1ps

module ogom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/ogom_prep.sv @@
`timescale 1ns / 1ps

module ogom_prep (
  input  logic                                clk,
  input  logic                                accept,
  input  logic [3:0]                          cell_shift,
  input  logic [2:0]                          in_func,
  input  logic [7:0]                          in_owner_id,
  input  logic signed [ogom_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [ogom_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [ogom_pkg::POS_W-1:0]   in_pos_z,
  input  logic signed [ogom_pkg::POS_W-1:0]   in_old_x,
  input  logic signed [ogom_pkg::POS_W-1:0]   in_old_y,
  input  logic signed [ogom_pkg::POS_W-1:0]   in_old_z,
  output ogom_pkg::item_t                     item
);

  import ogom_pkg::*;

  item_t item_r;
  item_t item_nxt;

  always_comb begin
    item_nxt.func     = in_func;
    item_nxt.owner_id = in_owner_id;
    item_nxt.new_c    = to_cell(in_pos_x, cell_shift);
    item_nxt.new_r    = to_cell(in_pos_z, cell_shift);
    item_nxt.old_c    = to_cell(in_old_x, cell_shift);
    item_nxt.old_r    = to_cell(in_old_z, cell_shift);
    item_nxt.dx       = abs_diff(in_pos_x, in_old_x);
    item_nxt.dy       = abs_diff(in_pos_y, in_old_y);
    item_nxt.dz       = abs_diff(in_pos_z, in_old_z);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item = item_r;

endmodule

@@ hdl/ogom_seq.sv @@
`timescale 1ns / 1ps

module ogom_seq #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64,
  parameter int ID_BITS  = 8,
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  ogom_pkg::item_t               item,
  input  logic [6:0]                    cfg_cols,
  input  logic [6:0]                    cfg_rows,
  input  logic [ogom_pkg::DIST_W-1:0]   cfg_thr,
  output logic                          busy,
  output logic                          out_strobe,
  output logic                          out_ok,
  output logic [7:0]                    out_found_owner,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [ID_BITS-1:0]            mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [ID_BITS-1:0]            mem_q
);

  import ogom_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int CW    = CELL_W + 1;
  localparam int CB    = $clog2(MAX_COLS);
  localparam int RB    = $clog2(MAX_ROWS);
  localparam logic signed [CW-1:0] ONE_S = CW'(1);
  localparam logic signed [CW-1:0] MC_S  = CW'(MAX_COLS);
  localparam logic signed [CW-1:0] MR_S  = CW'(MAX_ROWS);

  function automatic logic in_grid(input logic signed [CW-1:0] c,
                                   input logic signed [CW-1:0] r,
                                   input logic [6:0] gc,
                                   input logic [6:0] gr);
    return !c[CW-1] && !r[CW-1] && (c < $signed(CW'(gc))) && (c < MC_S) &&
           (r < $signed(CW'(gr))) && (r < MR_S);
  endfunction

  st_t state_r, state_nxt;

  logic [AW-1:0]      clr_addr_r;
  logic [1:0]         dc_r, dr_r;
  logic               pass_r, last_pass_r;
  logic               rd_pend_r, rd_mod_r, rd_claim_r;
  logic [AW-1:0]      rd_addr_r;
  logic               fwd_en_r;
  logic [AW-1:0]      fwd_addr_r;
  logic [ID_BITS-1:0] fwd_data_r;
  logic               ok_r;
  logic [7:0]         found_r;

  logic [ID_BITS-1:0]       id;
  logic                     sel_old;
  logic signed [CELL_W-1:0] base_c, base_r;
  logic signed [CW-1:0]     base_cw, base_rw, nc, nr;
  logic                     slot_in, center_in;
  logic [AW-1:0]            slot_addr;
  logic [DIST_W-1:0]        move_len;
  logic                     go;
  logic                     pass_claim;
  logic                     sweep_last;
  logic                     rd_issue;
  logic                     clearing;
  logic [ID_BITS-1:0]       cur;
  logic                     rmw_we;

  assign id      = ID_BITS'(item.owner_id);
  assign sel_old = !pass_r && (item.func == FN_MOVE);
  assign base_c  = sel_old ? item.old_c : item.new_c;
  assign base_r  = sel_old ? item.old_r : item.new_r;
  assign base_cw = CW'(base_c);
  assign base_rw = CW'(base_r);
  assign nc      = base_cw + $signed({{(CW-2){1'b0}}, dc_r}) - ONE_S;
  assign nr      = base_rw + $signed({{(CW-2){1'b0}}, dr_r}) - ONE_S;
  assign slot_in = in_grid(nc, nr, cfg_cols, cfg_rows);
  assign slot_addr = AW'(AW'(nr[RB-1:0]) * AW'(MAX_COLS)) + AW'(nc[CB-1:0]);
  assign center_in = in_grid(CW'(item.new_c), CW'(item.new_r), cfg_cols, cfg_rows);

  assign move_len = DIST_W'(item.dx) + DIST_W'(item.dy) + DIST_W'(item.dz);
  assign go       = move_len >= cfg_thr;

  assign pass_claim = (item.func == FN_CLAIM) || ((item.func == FN_MOVE) && pass_r);
  assign sweep_last = (dc_r == 2'd2) && (dr_r == 2'd2) && (pass_r == last_pass_r);

  // back-to-back access to the same cell: take the write just made
  assign cur    = (fwd_en_r && (fwd_addr_r == rd_addr_r)) ? fwd_data_r : mem_q;
  assign rmw_we = rd_pend_r && rd_mod_r &&
                  (rd_claim_r ? (cur == '0) : ((cur != '0) && (cur == id)));

  assign mem_we    = clearing ? 1'b1 : rmw_we;
  assign mem_waddr = clearing ? clr_addr_r : rd_addr_r;
  assign mem_wdata = (clearing || !rd_claim_r) ? '0 : id;
  assign mem_raddr = slot_addr;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        case (item.func)
          FN_CHECK, FN_QUERY:   state_nxt = ST_LOOK;
          FN_CLAIM, FN_RELEASE: state_nxt = ST_SWEEP;
          FN_MOVE:              state_nxt = go ? ST_SWEEP : ST_DONE;
          default:              state_nxt = ST_DONE;
        endcase
      end
      ST_LOOK: state_nxt = ST_DRAIN;
      ST_SWEEP: begin
        if (sweep_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    out_strobe = 1'b0;
    rd_issue   = 1'b0;
    clearing   = 1'b0;
    case (state_r)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  busy = 1'b0;
      ST_LOOK, ST_SWEEP: rd_issue = slot_in;
      ST_DONE:  out_strobe = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      rd_pend_r  <= 1'b0;
      fwd_en_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clearing ? clr_addr_r + AW'(1) : clr_addr_r;
      rd_pend_r  <= rd_issue;
      fwd_en_r   <= mem_we;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= slot_addr;
    rd_mod_r   <= (state_r == ST_SWEEP);
    rd_claim_r <= pass_claim;
    fwd_addr_r <= mem_waddr;
    fwd_data_r <= mem_wdata;
    case (state_r)
      ST_SETUP: begin
        dc_r        <= (item.func inside {FN_CHECK, FN_QUERY}) ? 2'd1 : 2'd0;
        dr_r        <= (item.func inside {FN_CHECK, FN_QUERY}) ? 2'd1 : 2'd0;
        pass_r      <= 1'b0;
        last_pass_r <= (item.func == FN_MOVE);
        found_r     <= '0;
        case (item.func)
          FN_QUERY, FN_CLAIM, FN_RELEASE: ok_r <= center_in;
          FN_MOVE:                        ok_r <= go;
          default:                        ok_r <= 1'b0;
        endcase
      end
      ST_SWEEP: begin
        if (dc_r == 2'd2) begin
          dc_r <= 2'd0;
          if (dr_r == 2'd2) begin
            dr_r   <= 2'd0;
            pass_r <= 1'b1;
          end else begin
            dr_r <= dr_r + 2'd1;
          end
        end else begin
          dc_r <= dc_r + 2'd1;
        end
      end
      ST_DRAIN: begin
        if (rd_pend_r && (item.func == FN_CHECK)) ok_r <= (cur == '0) || (cur == id);
        if (rd_pend_r && (item.func == FN_QUERY)) found_r <= 8'(cur);
      end
      default: ;
    endcase
  end

  assign out_ok          = ok_r;
  assign out_found_owner = found_r;

  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SETUP)) else $error("accepted item did not enter setup");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe longer than one cycle");

  a_quiet_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) || (state_r == ST_DONE) || (state_r == ST_SETUP)) |-> !mem_we)
    else $error("grid write outside an update");

  a_clear_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (mem_we && (mem_wdata == '0)))
    else $error("clear pass not writing empty");

  a_setup_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SETUP) |-> !rd_pend_r) else $error("stale read pending at setup");

endmodule

@@ hdl/occupancy_grid_owner_map.sv @@
`timescale 1ns / 1ps

// Owner-id occupancy grid with check, query, claim, release and move
// operations. An item is taken when start is high and busy is low; its single
// result appears on out_ok / out_found_owner for exactly one cycle with
// out_strobe high, and the receiver cannot stall it. The grid sits in one
// RAM with one write and one registered read port, and the sequencer visits
// one cell per cycle. After setup, check and query read the centre cell, claim
// and release sweep its 3x3 block, a move above threshold sweeps the old block
// and then the new one, and a move below threshold or an unknown func goes to
// the strobe after setup. Busy then drops in the next cycle. After reset the
// block is busy while it clears the grid one cell per cycle; configuration
// writes are taken at all times but must only be made while the block is idle.
module occupancy_grid_owner_map #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64,
  parameter int ID_BITS  = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         in_func,
  input  logic [7:0]                         in_owner_id,
  input  logic signed [ogom_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [ogom_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [ogom_pkg::POS_W-1:0]  in_pos_z,
  input  logic signed [ogom_pkg::POS_W-1:0]  in_old_x,
  input  logic signed [ogom_pkg::POS_W-1:0]  in_old_y,
  input  logic signed [ogom_pkg::POS_W-1:0]  in_old_z,
  output logic                               out_strobe,
  output logic                               out_ok,
  output logic [7:0]                         out_found_owner,
  input  logic                               cfg_we,
  input  logic [ogom_pkg::IDX_W-1:0]         cfg_index,
  input  logic [ogom_pkg::CFG_W-1:0]         cfg_wdata
);

  import ogom_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  logic [6:0]        cols_r, rows_r;
  logic [3:0]        shift_r;
  logic [DIST_W-1:0] thr_r;

  logic               accept;
  item_t              item;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [ID_BITS-1:0] mem_wdata, mem_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= 7'd64;
      rows_r  <= 7'd64;
      shift_r <= 4'd8;
      thr_r   <= DIST_W'(80);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_COLS:      cols_r  <= cfg_wdata[6:0];
        REG_GRID_ROWS:      rows_r  <= cfg_wdata[6:0];
        REG_CELL_SHIFT:     shift_r <= cfg_wdata[3:0];
        REG_MOVE_THRESHOLD: thr_r   <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = start && !busy;

  ogom_prep u_prep (
    .clk         (clk),
    .accept      (accept),
    .cell_shift  (shift_r),
    .in_func     (in_func),
    .in_owner_id (in_owner_id),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_pos_z    (in_pos_z),
    .in_old_x    (in_old_x),
    .in_old_y    (in_old_y),
    .in_old_z    (in_old_z),
    .item        (item)
  );

  ogom_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  ogom_seq #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .ID_BITS  (ID_BITS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .item            (item),
    .cfg_cols        (cols_r),
    .cfg_rows        (rows_r),
    .cfg_thr         (thr_r),
    .busy            (busy),
    .out_strobe      (out_strobe),
    .out_ok          (out_ok),
    .out_found_owner (out_found_owner),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_q           (mem_q)
  );

endmodule

@@ tb/occupancy_grid_owner_map_tb.sv @@
`timescale 1ns / 1ps

module occupancy_grid_owner_map_tb;
  import ogom_pkg::*;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int N_DIRECTED = 25;
  localparam int N_PHASES = 10;

  // funcs the block does not know
  localparam logic [2:0] FN_RSVD5 = 3'd5;
  localparam logic [2:0] FN_RSVD6 = 3'd6;
  localparam logic [2:0] FN_RSVD7 = 3'd7;

  typedef struct packed {
    logic [2:0]              func;
    logic [7:0]              owner;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic signed [POS_W-1:0] ox;
    logic signed [POS_W-1:0] oy;
    logic signed [POS_W-1:0] oz;
  } grid_op_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] found;
  } grid_ans_t;

  typedef struct packed {
    grid_op_t  op;
    logic      typed;
    grid_ans_t ans;
  } directed_row_t;

  typedef struct packed {
    logic [6:0]  cols;
    logic [6:0]  rows;
    logic [3:0]  sh;
    logic [17:0] thr;
    int          n_items;
    int          idle_pct;
  } phase_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [2:0]            in_func;
  logic [7:0]            in_owner_id;
  logic signed [POS_W-1:0] in_pos_x;
  logic signed [POS_W-1:0] in_pos_y;
  logic signed [POS_W-1:0] in_pos_z;
  logic signed [POS_W-1:0] in_old_x;
  logic signed [POS_W-1:0] in_old_y;
  logic signed [POS_W-1:0] in_old_z;
  logic                  out_strobe;
  logic                  out_ok;
  logic [7:0]            out_found_owner;
  logic                  cfg_we;
  logic [IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  occupancy_grid_owner_map #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS),
    .ID_BITS (8)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_owner_id    (in_owner_id),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_old_x       (in_old_x),
    .in_old_y       (in_old_y),
    .in_old_z       (in_old_z),
    .out_strobe     (out_strobe),
    .out_ok         (out_ok),
    .out_found_owner(out_found_owner),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // mirror of the grid and its registers
  logic [7:0]  occ_grid [MAX_ROWS*MAX_COLS];
  logic [6:0]  occ_cols;
  logic [6:0]  occ_rows;
  logic [3:0]  occ_shift;
  logic [17:0] occ_thr;

  logic signed [POS_W-1:0] last_x [256];
  logic signed [POS_W-1:0] last_y [256];
  logic signed [POS_W-1:0] last_z [256];

  grid_ans_t pending_answers [$];
  int        n_bad;

  directed_row_t directed_ops [N_DIRECTED] = '{
    '{'{FN_QUERY,   8'd0,   0,      0,      0,      0,      0,      0},      1'b1, '{1'b1, 8'd0}},
    '{'{FN_CHECK,   8'd5,   0,      0,      0,      0,      0,      0},      1'b1, '{1'b1, 8'd0}},
    '{'{FN_CLAIM,   8'd5,   256,    0,      256,    0,      0,      0},      1'b1, '{1'b1, 8'd0}},
    '{'{FN_QUERY,   8'd1,   0,      0,      0,      0,      0,      0},      1'b0, '0},
    '{'{FN_CHECK,   8'd6,   0,      0,      0,      0,      0,      0},      1'b0, '0},
    '{'{FN_CHECK,   8'd0,   0,      0,      0,      0,      0,      0},      1'b0, '0},
    '{'{FN_CLAIM,   8'd0,   1280,   0,      1280,   0,      0,      0},      1'b0, '0},
    '{'{FN_RELEASE, 8'd0,   256,    0,      256,    0,      0,      0},      1'b0, '0},
    '{'{FN_QUERY,   8'd9,   -255,   0,      -1,     0,      0,      0},      1'b0, '0},
    '{'{FN_QUERY,   8'd9,   -256,   0,      0,      0,      0,      0},      1'b1, '{1'b0, 8'd0}},
    '{'{FN_QUERY,   8'd9,   32767,  32767,  32767,  32767,  32767,  32767},  1'b1, '{1'b0, 8'd0}},
    '{'{FN_QUERY,   8'd9,   -32768, -32768, -32768, -32768, -32768, -32768}, 1'b1, '{1'b0, 8'd0}},
    '{'{FN_CLAIM,   8'd255, 16383,  0,      16383,  0,      0,      0},      1'b1, '{1'b1, 8'd0}},
    '{'{FN_QUERY,   8'd1,   16383,  0,      16383,  0,      0,      0},      1'b0, '0},
    '{'{FN_RELEASE, 8'd5,   256,    0,      256,    0,      0,      0},      1'b0, '0},
    '{'{FN_QUERY,   8'd1,   0,      0,      0,      0,      0,      0},      1'b0, '0},
    '{'{FN_MOVE,    8'd7,   0,      0,      0,      1,      1,      1},      1'b1, '{1'b0, 8'd0}},
    '{'{FN_MOVE,    8'd7,   80,     0,      0,      0,      0,      0},      1'b1, '{1'b1, 8'd0}},
    '{'{FN_MOVE,    8'd7,   4000,   -32768, 4000,   80,     0,      0},      1'b0, '0},
    '{'{FN_MOVE,    8'd170, 32767,  32767,  32767,  -32768, -32768, -32768}, 1'b1, '{1'b1, 8'd0}},
    '{'{FN_RSVD5,   8'd255, 256,    0,      256,    0,      0,      0},      1'b1, '{1'b0, 8'd0}},
    '{'{FN_RSVD6,   8'd85,  0,      0,      0,      0,      0,      0},      1'b1, '{1'b0, 8'd0}},
    '{'{FN_RSVD7,   8'd5,   256,    0,      256,    0,      0,      0},      1'b1, '{1'b0, 8'd0}},
    '{'{FN_RELEASE, 8'd255, 16383,  0,      16383,  0,      0,      0},      1'b0, '0},
    '{'{FN_CHECK,   8'd255, 16383,  0,      16383,  0,      0,      0},      1'b0, '0}
  };

  phase_t phases [N_PHASES] = '{
    '{7'd64,  7'd64,  4'd8,  18'd80,     160, 40},
    '{7'd1,   7'd1,   4'd0,  18'd0,      100, 30},
    '{7'd64,  7'd64,  4'd12, 18'd196605, 150, 60},
    '{7'd0,   7'd5,   4'd4,  18'd100,    80,  20},
    '{7'd127, 7'd127, 4'd15, 18'd1000,   100, 50},
    '{7'd8,   7'd8,   4'd5,  18'd200,    200, 0},
    '{7'd13,  7'd7,   4'd13, 18'd50000,  150, 40},
    '{7'd3,   7'd64,  4'd6,  18'd30,     150, 30},
    '{7'd16,  7'd16,  4'd8,  18'd80,     150, 40},
    '{7'd16,  7'd16,  4'd8,  18'd80,     140, 0}
  };

  always #5 clk = ~clk;

  function automatic int used_span(logic [6:0] n, int lim);
    return (int'(n) > lim) ? lim : int'(n);
  endfunction

  function automatic int cell_of(logic signed [POS_W-1:0] v);
    int sv;
    int mag;
    sv  = v;
    mag = (sv < 0) ? -sv : sv;
    mag = mag >> occ_shift;
    return (sv < 0) ? -mag : mag;
  endfunction

  function automatic bit on_grid(int c, int r);
    return c >= 0 && r >= 0 && c < used_span(occ_cols, MAX_COLS) &&
           r < used_span(occ_rows, MAX_ROWS);
  endfunction

  function automatic void sweep_block(int c, int r, logic [7:0] id, bit claim);
    int k;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (on_grid(c + dc, r + dr)) begin
          k = (r + dr) * MAX_COLS + (c + dc);
          if (claim) begin
            if (occ_grid[k] == 8'd0) occ_grid[k] = id;
          end else if (occ_grid[k] != 8'd0 && occ_grid[k] == id) begin
            occ_grid[k] = 8'd0;
          end
        end
      end
    end
  endfunction

  function automatic int pos_gap(logic signed [POS_W-1:0] a, logic signed [POS_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic grid_ans_t predict_grid_op(grid_op_t op);
    grid_ans_t ans;
    int        c;
    int        r;
    int        travel;
    logic [7:0] v;
    ans = '0;
    c = cell_of(op.px);
    r = cell_of(op.pz);
    case (op.func)
      FN_CHECK: begin
        if (on_grid(c, r)) begin
          v = occ_grid[r * MAX_COLS + c];
          ans.ok = (v == 8'd0 || v == op.owner);
        end
      end
      FN_QUERY: begin
        ans.ok = on_grid(c, r);
        if (ans.ok) ans.found = occ_grid[r * MAX_COLS + c];
      end
      FN_CLAIM: begin
        ans.ok = on_grid(c, r);
        sweep_block(c, r, op.owner, 1'b1);
      end
      FN_RELEASE: begin
        ans.ok = on_grid(c, r);
        sweep_block(c, r, op.owner, 1'b0);
      end
      FN_MOVE: begin
        travel = pos_gap(op.px, op.ox) + pos_gap(op.py, op.oy) + pos_gap(op.pz, op.oz);
        if (travel >= int'(occ_thr)) begin
          sweep_block(cell_of(op.ox), cell_of(op.oz), op.owner, 1'b0);
          sweep_block(c, r, op.owner, 1'b1);
          ans.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return POS_W'(v);
  endfunction

  // a position inside cell c; cell 0 also takes small negatives
  function automatic logic signed [POS_W-1:0] pos_in_cell(int c);
    int step;
    int frac;
    step = 1 << occ_shift;
    frac = int'($urandom_range(0, step - 1));
    if (c > 0 || (c == 0 && $urandom_range(0, 1) == 0)) return clamp16(c * step + frac);
    return clamp16(c * step - frac);
  endfunction

  function automatic grid_op_t make_random_op();
    grid_op_t op;
    int       roll;
    int       c;
    int       r;
    int       span;
    roll = $urandom_range(0, 99);
    if (roll < 12) op.func = FN_CHECK;
    else if (roll < 24) op.func = FN_QUERY;
    else if (roll < 44) op.func = FN_CLAIM;
    else if (roll < 58) op.func = FN_RELEASE;
    else if (roll < 93) op.func = FN_MOVE;
    else op.func = 3'($urandom_range(FN_RSVD5, FN_RSVD7));
    roll = $urandom_range(0, 99);
    if (roll < 75) op.owner = 8'($urandom_range(1, 4));
    else if (roll < 80) op.owner = 8'd0;
    else op.owner = 8'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      op.px = POS_W'($urandom);
      op.py = POS_W'($urandom);
      op.pz = POS_W'($urandom);
      op.ox = POS_W'($urandom);
      op.oy = POS_W'($urandom);
      op.oz = POS_W'($urandom);
    end else begin
      c = int'($urandom_range(0, used_span(occ_cols, MAX_COLS) + 3)) - 2;
      r = int'($urandom_range(0, used_span(occ_rows, MAX_ROWS) + 3)) - 2;
      op.px = pos_in_cell(c);
      op.pz = pos_in_cell(r);
      op.py = clamp16(int'($urandom_range(0, 400)) - 200);
      op.ox = last_x[op.owner];
      op.oy = last_y[op.owner];
      op.oz = last_z[op.owner];
      if ($urandom_range(0, 3) == 0) begin
        // short hop around the move threshold
        span = (int'(occ_thr) > 40000) ? 20000 : int'(occ_thr) / 2 + 1;
        op.px = clamp16(int'(op.ox) + int'($urandom_range(0, 2 * span)) - span);
        op.py = clamp16(int'(op.oy) + int'($urandom_range(0, 2 * span)) - span);
        op.pz = clamp16(int'(op.oz) + int'($urandom_range(0, 2 * span)) - span);
      end
      if ($urandom_range(0, 9) == 0) begin
        op.ox = pos_in_cell(int'($urandom_range(0, 6)) - 3);
        op.oz = pos_in_cell(int'($urandom_range(0, 6)) - 3);
      end
    end
    return op;
  endfunction

  task automatic idle_burst();
    start = 1'b0;
    repeat ($urandom_range(1, 18)) @(negedge clk);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(input grid_op_t op, input logic typed, input grid_ans_t typed_ans);
    grid_ans_t got;
    in_func     = op.func;
    in_owner_id = op.owner;
    in_pos_x    = op.px;
    in_pos_y    = op.py;
    in_pos_z    = op.pz;
    in_old_x    = op.ox;
    in_old_y    = op.oy;
    in_old_z    = op.oz;
    start       = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = predict_grid_op(op);
    pending_answers.insert(pending_answers.size(), typed ? typed_ans : got);
    if (op.func inside {FN_MOVE, FN_CLAIM}) begin
      last_x[op.owner] = op.px;
      last_y[op.owner] = op.py;
      last_z[op.owner] = op.pz;
    end
    @(negedge clk);
  endtask

  task automatic settle();
    start = 1'b0;
    while (pending_answers.size() != 0 || busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_GRID_COLS:      occ_cols  = val[6:0];
      REG_GRID_ROWS:      occ_rows  = val[6:0];
      REG_CELL_SHIFT:     occ_shift = val[3:0];
      REG_MOVE_THRESHOLD: occ_thr   = val[17:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    grid_ans_t want;
    if (rst_n && out_strobe) begin
      if (pending_answers.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t: result with no item pending: ok %0b owner %0d",
                   $realtime, out_ok, out_found_owner);
      end else begin
        want = pending_answers.pop_front();
        if (out_ok !== want.ok || out_found_owner !== want.found) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: mismatch: ok %0b owner %0d, expected ok %0b owner %0d",
                     $realtime, out_ok, out_found_owner, want.ok, want.found);
        end
      end
    end
  end

  initial begin
    #6_000_000;
    $display("** occupancy_grid_owner_map: FAILED **");
    $finish;
  end

  initial begin
    phase_t ph;
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_func     = FN_CHECK;
    in_owner_id = '0;
    in_pos_x    = '0;
    in_pos_y    = '0;
    in_pos_z    = '0;
    in_old_x    = '0;
    in_old_y    = '0;
    in_old_z    = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_GRID_COLS;
    cfg_wdata   = '0;
    n_bad       = 0;
    occ_cols    = 7'd64;
    occ_rows    = 7'd64;
    occ_shift   = 4'd8;
    occ_thr     = 18'd80;
    foreach (occ_grid[k]) occ_grid[k] = 8'd0;
    foreach (last_x[k]) begin
      last_x[k] = '0;
      last_y[k] = '0;
      last_z[k] = '0;
    end
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      issue(directed_ops[i].op, directed_ops[i].typed, directed_ops[i].ans);
      if ($urandom_range(0, 1) == 0) idle_burst();
    end

    phases[8].cols = 7'($urandom_range(1, 64));
    phases[8].rows = 7'($urandom_range(1, 64));
    phases[8].sh   = 4'($urandom_range(0, 10));
    phases[8].thr  = 18'($urandom_range(0, 3000));
    phases[9].cols = 7'($urandom_range(1, 64));
    phases[9].rows = 7'($urandom_range(1, 64));
    phases[9].sh   = 4'($urandom_range(0, 10));
    phases[9].thr  = 18'($urandom_range(0, 3000));

    for (int p = 0; p < N_PHASES; p++) begin
      ph = phases[p];
      settle();
      // upper data bits are don't-care for the narrow registers
      write_reg(REG_GRID_COLS, {11'($urandom), ph.cols});
      write_reg(REG_GRID_ROWS, {11'($urandom), ph.rows});
      write_reg(REG_CELL_SHIFT, {14'($urandom), ph.sh});
      write_reg(REG_MOVE_THRESHOLD, ph.thr);
      for (int n = 0; n < ph.n_items; n++) begin
        issue(make_random_op(), 1'b0, '0);
        if (int'($urandom_range(0, 99)) < ph.idle_pct) idle_burst();
      end
    end

    settle();
    repeat (30) @(posedge clk);
    if (n_bad == 0 && pending_answers.size() == 0) begin
      $display("** occupancy_grid_owner_map: PASSED **");
    end else begin
      $display("** occupancy_grid_owner_map: FAILED **");
    end
    $finish;
  end

endmodule
